### sv/ogse_pkg.sv
package ogse_pkg;

  localparam int GRID_SIZE = 128;
  localparam int ROW_W     = $clog2(GRID_SIZE);
  localparam int CNT_W     = $clog2(GRID_SIZE + 1);
  localparam int POS_W     = 8;
  localparam int ORG_W     = POS_W + 3;
  localparam int HIT_W     = 7;

  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef logic [GRID_SIZE-1:0] row_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] side_len;
    logic             is_centered;
  } item_t;

  typedef struct packed {
    logic             in_bounds;
    logic             hit;
    logic [HIT_W-1:0] hit_x;
    logic [HIT_W-1:0] hit_y;
  } result_t;

  typedef struct packed {
    logic latch;
    logic calc_origin;
    logic calc_mask;
    logic issue;
    logic clear_all;
    logic encode;
  } ctl_t;

  typedef struct packed {
    logic is_clear;
    logic is_test;
    logic inb;
    logic side_zero;
    logic last;
    logic found;
  } status_t;

endpackage

### sv/ogse_ram.sv
module ogse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ogse_dp.sv
module ogse_dp (
  input  logic             clk,
  input  logic             rst,
  input  ogse_pkg::item_t  item,
  input  ogse_pkg::ctl_t   ctl,
  output ogse_pkg::status_t st,
  output ogse_pkg::result_t result
);

  ogse_pkg::item_t                 item_r;
  ogse_pkg::row_t                  mask;
  ogse_pkg::row_t                  row_valid;
  ogse_pkg::row_t                  rdata;
  ogse_pkg::row_t                  row_data;
  ogse_pkg::row_t                  masked;
  ogse_pkg::row_t                  hit_row;
  ogse_pkg::row_t                  wdata;
  logic [ogse_pkg::ROW_W-1:0]      ox, oy;
  logic [ogse_pkg::ROW_W-1:0]      row;
  logic [ogse_pkg::ROW_W-1:0]      rd_row;
  logic [ogse_pkg::CNT_W-1:0]      remaining;
  logic [ogse_pkg::CNT_W-1:0]      side_cnt;
  logic                            rd_valid;
  logic                            we;

  logic [ogse_pkg::POS_W-1:0]        half;
  logic                              centered;
  logic                              inb_c;
  logic signed [ogse_pkg::ORG_W-1:0] grid_s, px_s, py_s, side_s, half_s, ox_s, oy_s;

  function automatic logic [ogse_pkg::ROW_W-1:0] low_index(input ogse_pkg::row_t v);
    logic [ogse_pkg::ROW_W-1:0] idx;
    idx = '0;
    for (int i = ogse_pkg::GRID_SIZE - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ogse_pkg::ROW_W'(i);
      end
    end
    return idx;
  endfunction

  // Origin and bounds
  always_comb begin
    grid_s   = ogse_pkg::ORG_W'(ogse_pkg::GRID_SIZE);
    px_s     = ogse_pkg::ORG_W'(item_r.pos_x);
    py_s     = ogse_pkg::ORG_W'(item_r.pos_y);
    side_s   = ogse_pkg::ORG_W'(item_r.side_len);
    half     = (item_r.side_len - ogse_pkg::POS_W'(1)) >> 1;
    half_s   = ogse_pkg::ORG_W'(half);
    centered = item_r.is_centered && (item_r.side_len != '0);
    ox_s     = centered ? px_s - half_s : px_s;
    oy_s     = centered ? py_s - half_s : py_s;
    inb_c    = !(item_r.is_centered && (item_r.side_len == '0)) &&
               !ox_s[ogse_pkg::ORG_W-1] && !oy_s[ogse_pkg::ORG_W-1] &&
               (ox_s < grid_s) && (oy_s < grid_s) &&
               (ox_s + side_s <= grid_s) && (oy_s + side_s <= grid_s) &&
               (px_s < grid_s) && (py_s < grid_s);
  end

  assign side_cnt = ogse_pkg::CNT_W'(item_r.side_len);
  assign row_data = row_valid[rd_row] ? rdata : '0;
  assign masked   = row_data & mask;
  assign wdata    = (item_r.command == ogse_pkg::CMD_FILL) ? (row_data | mask)
                                                            : (row_data & ~mask);
  assign we       = rd_valid && (item_r.command != ogse_pkg::CMD_TEST);

  always_comb begin
    st.is_clear  = item_r.command == ogse_pkg::CMD_CLEAR;
    st.is_test   = item_r.command == ogse_pkg::CMD_TEST;
    st.inb       = result.in_bounds;
    st.side_zero = item_r.side_len == '0;
    st.last      = remaining == ogse_pkg::CNT_W'(1);
    st.found     = rd_valid && st.is_test && (masked != '0);
  end

  ogse_ram #(
    .WIDTH(ogse_pkg::GRID_SIZE),
    .DEPTH(ogse_pkg::GRID_SIZE)
  ) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(rd_row),
    .wdata(wdata),
    .raddr(row),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= ctl.issue;
      if (ctl.clear_all) begin
        row_valid <= '0;
      end else if (we) begin
        row_valid[rd_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_r       <= item;
      result.hit   <= 1'b0;
      result.hit_x <= '0;
      result.hit_y <= '0;
    end
    if (ctl.calc_origin) begin
      ox               <= ox_s[ogse_pkg::ROW_W-1:0];
      oy               <= oy_s[ogse_pkg::ROW_W-1:0];
      result.in_bounds <= inb_c;
    end
    if (ctl.calc_mask) begin
      mask      <= ({ogse_pkg::GRID_SIZE{1'b1}} >> (ogse_pkg::CNT_W'(ogse_pkg::GRID_SIZE) - side_cnt))
                   << ox;
      remaining <= side_cnt;
      // test walks from the top row down, fill and erase walk up
      if (item_r.command == ogse_pkg::CMD_TEST) begin
        row <= ogse_pkg::ROW_W'(ogse_pkg::CNT_W'(oy) + side_cnt - ogse_pkg::CNT_W'(1));
      end else begin
        row <= oy;
      end
    end
    if (ctl.issue) begin
      rd_row    <= row;
      remaining <= remaining - ogse_pkg::CNT_W'(1);
      row       <= (item_r.command == ogse_pkg::CMD_TEST) ? row - ogse_pkg::ROW_W'(1)
                                                          : row + ogse_pkg::ROW_W'(1);
    end
    if (st.found) begin
      hit_row      <= masked;
      result.hit_y <= ogse_pkg::HIT_W'(rd_row);
    end
    if (ctl.encode) begin
      result.hit   <= 1'b1;
      result.hit_x <= ogse_pkg::HIT_W'(low_index(hit_row));
    end
  end

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    we |-> !ctl.clear_all)
    else $error("row write during grid clear");

endmodule

### sv/ogse_ctrl.sv
module ogse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ogse_pkg::status_t st,
  output ogse_pkg::ctl_t    ctl,
  output logic              busy,
  output logic              done
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ORIGIN = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_ENCODE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  always_comb begin
    state_next      = state;
    ctl             = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        ctl.calc_origin = 1'b1;
        state_next      = S_PREP;
      end
      S_PREP: begin
        if (st.is_clear) begin
          ctl.clear_all = 1'b1;
          state_next    = S_DONE;
        end else if (!st.inb || st.side_zero) begin
          state_next = S_DONE;
        end else begin
          ctl.calc_mask = 1'b1;
          state_next    = S_RUN;
        end
      end
      S_RUN: begin
        if (st.found) begin
          state_next = S_ENCODE;
        end else begin
          ctl.issue = 1'b1;
          if (st.last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_next = st.found ? S_ENCODE : S_DONE;
      end
      S_ENCODE: begin
        ctl.encode = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_issue_in_bounds: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> (st.inb && !st.is_clear && !st.side_zero))
    else $error("row access for an item that touches no rows");

  a_encode_after_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENCODE) |-> $past(st.found))
    else $error("encode without an occupied row");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

### sv/occupancy_grid_square_engine_unit.sv
// Occupancy grid square engine: a 128 x 128 bitmap of occupied cells.
// Command channel: an item (command, pos_x, pos_y, side_len, is_centered)
// is taken at a rising edge with start high and busy low. busy stays high
// until the result has been shown.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot hold it off and must take it in that cycle.
// Sequence: the item walks one bitmap row per cycle through a two-port
// row memory with registered read. Fill, erase and a test with no hit
// walk every row of the square before done; a test that hits stops early at
// the first occupied row. Clear-all, out-of-bounds squares and empty
// squares skip the row walk. A new item may start the cycle after done;
// the block takes one item at a time.
// Reset: rst is synchronous and active high; it empties the bitmap at once
// through per-row valid bits and returns the sequencer to idle.
module occupancy_grid_square_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ogse_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output ogse_pkg::result_t result
);

  ogse_pkg::ctl_t    ctl;
  ogse_pkg::status_t st;

  ogse_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .ctl  (ctl),
    .busy (busy),
    .done (done)
  );

  ogse_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .ctl   (ctl),
    .st    (st),
    .result(result)
  );

endmodule

### verif/occupancy_grid_square_engine_unit_tb.sv
module occupancy_grid_square_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst;
  logic              start;
  ogse_pkg::item_t   item;
  logic              busy;
  logic              done;
  ogse_pkg::result_t result;

  ogse_pkg::row_t    shadow_rows [ogse_pkg::GRID_SIZE];
  ogse_pkg::result_t pending_results [$];
  int                error_count;
  int                sent_count;

  occupancy_grid_square_engine_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic ogse_pkg::item_t make_item(logic [1:0] cmd, int x, int y, int side,
                                                bit centered);
    ogse_pkg::item_t it;
    it.command     = cmd;
    it.pos_x       = ogse_pkg::POS_W'(x);
    it.pos_y       = ogse_pkg::POS_W'(y);
    it.side_len    = ogse_pkg::POS_W'(side);
    it.is_centered = centered;
    return it;
  endfunction

  // Apply one command to the shadow bitmap and return the result it must produce.
  function automatic ogse_pkg::result_t apply_square_command(ogse_pkg::item_t it);
    int                px;
    int                py;
    int                side;
    int                ox;
    int                oy;
    int                xx;
    int                yy;
    logic              inb;
    logic              found;
    ogse_pkg::result_t r;
    px    = it.pos_x;
    py    = it.pos_y;
    side  = it.side_len;
    ox    = px;
    oy    = py;
    inb   = 1'b1;
    found = 1'b0;
    r     = '0;
    if (it.is_centered) begin
      if (side == 0) begin
        inb = 1'b0;
      end else begin
        ox = px - (side - 1) / 2;
        oy = py - (side - 1) / 2;
      end
    end
    if (ox < 0 || ox > ogse_pkg::GRID_SIZE - 1 || oy < 0 || oy > ogse_pkg::GRID_SIZE - 1)
      inb = 1'b0;
    if (ox + side > ogse_pkg::GRID_SIZE || oy + side > ogse_pkg::GRID_SIZE) inb = 1'b0;
    if (px > ogse_pkg::GRID_SIZE - 1 || py > ogse_pkg::GRID_SIZE - 1) inb = 1'b0;
    r.in_bounds = inb;
    case (it.command)
      ogse_pkg::CMD_CLEAR: begin
        for (yy = 0; yy < ogse_pkg::GRID_SIZE; yy++) shadow_rows[yy] = '0;
      end
      ogse_pkg::CMD_TEST: begin
        // scan from the top row down, each row left to right
        if (inb) begin
          for (yy = oy + side - 1; yy >= oy && !found; yy--) begin
            for (xx = ox; xx < ox + side && !found; xx++) begin
              if (shadow_rows[yy][xx]) begin
                found   = 1'b1;
                r.hit   = 1'b1;
                r.hit_x = ogse_pkg::HIT_W'(xx);
                r.hit_y = ogse_pkg::HIT_W'(yy);
              end
            end
          end
        end
      end
      default: begin
        if (inb) begin
          for (yy = oy; yy < oy + side; yy++)
            for (xx = ox; xx < ox + side; xx++)
              shadow_rows[yy][xx] = (it.command == ogse_pkg::CMD_FILL);
        end
      end
    endcase
    return r;
  endfunction

  // Present one item and hold it until the block takes it; start stays high.
  task automatic send_item(ogse_pkg::item_t it);
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_square_command(it));
    sent_count++;
  endtask

  task automatic rest(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold off new items until every outstanding result is back.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, expected_val, actual_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    ogse_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("in_bounds", 32'(want.in_bounds), 32'(result.in_bounds));
        report_field("hit", 32'(want.hit), 32'(result.hit));
        report_field("hit_x", 32'(want.hit_x), 32'(result.hit_x));
        report_field("hit_y", 32'(want.hit_y), 32'(result.hit_y));
      end
    end
  end

  task automatic test_corner_cells;
    send_item(make_item(ogse_pkg::CMD_FILL, 0, 0, 1, 1'b0));
    send_item(make_item(ogse_pkg::CMD_FILL, 127, 127, 1, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 0, 0, 128, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 0, 0, 1, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 120, 120, 8, 1'b0));
    send_item(make_item(ogse_pkg::CMD_ERASE, 127, 127, 1, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 0, 0, 128, 1'b0));
  endtask

  task automatic test_bounds_edges;
    send_item(make_item(ogse_pkg::CMD_FILL, 255, 255, 255, 1'b1));
    send_item(make_item(ogse_pkg::CMD_FILL, 1, 0, 128, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 64, 64, 128, 1'b1));
    send_item(make_item(ogse_pkg::CMD_FILL, 63, 63, 127, 1'b1));
    send_item(make_item(ogse_pkg::CMD_TEST, 128, 0, 1, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 2, 2, 6, 1'b1));
    send_item(make_item(ogse_pkg::CMD_ERASE, 0, 0, 128, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 0, 0, 128, 1'b0));
  endtask

  task automatic test_empty_squares;
    send_item(make_item(ogse_pkg::CMD_FILL, 10, 10, 4, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 11, 11, 0, 1'b1));
    send_item(make_item(ogse_pkg::CMD_FILL, 20, 20, 0, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 11, 11, 0, 1'b0));
    send_item(make_item(ogse_pkg::CMD_ERASE, 12, 12, 0, 1'b0));
    send_item(make_item(ogse_pkg::CMD_TEST, 10, 10, 4, 1'b0));
  endtask

  task automatic test_clear_grid;
    send_item(make_item(ogse_pkg::CMD_CLEAR, 200, 3, 77, 1'b1));
    send_item(make_item(ogse_pkg::CMD_TEST, 0, 0, 128, 1'b0));
    send_item(make_item(ogse_pkg::CMD_FILL, 5, 5, 3, 1'b1));
    send_item(make_item(ogse_pkg::CMD_CLEAR, 0, 0, 0, 1'b0));
  endtask

  function automatic ogse_pkg::item_t random_square();
    ogse_pkg::item_t it;
    int              pick;
    int              side;
    int              half;
    logic [1:0]      cmd;
    pick = $urandom_range(99);
    if (pick < 38)      cmd = ogse_pkg::CMD_FILL;
    else if (pick < 58) cmd = ogse_pkg::CMD_ERASE;
    else if (pick < 97) cmd = ogse_pkg::CMD_TEST;
    else                cmd = ogse_pkg::CMD_CLEAR;
    if ($urandom_range(99) < 80) begin
      // well-formed square that fits the grid
      side = ($urandom_range(9) == 0) ? $urandom_range(1, ogse_pkg::GRID_SIZE)
                                      : $urandom_range(1, 12);
      it.is_centered = 1'($urandom_range(1));
      half = it.is_centered ? (side - 1) / 2 : 0;
      it.pos_x    = ogse_pkg::POS_W'($urandom_range(half, ogse_pkg::GRID_SIZE - side + half));
      it.pos_y    = ogse_pkg::POS_W'($urandom_range(half, ogse_pkg::GRID_SIZE - side + half));
      it.side_len = ogse_pkg::POS_W'(side);
    end else begin
      it.is_centered = 1'($urandom_range(1));
      it.pos_x       = ogse_pkg::POS_W'($urandom_range(255));
      it.pos_y       = ogse_pkg::POS_W'($urandom_range(255));
      it.side_len    = ogse_pkg::POS_W'($urandom_range(255));
    end
    it.command = cmd;
    return it;
  endfunction

  task automatic test_random_traffic(int count);
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        if (k < count) begin
          send_item(random_square());
          k++;
        end
      end
      if ($urandom_range(3) != 0) rest($urandom_range(0, 10));
      if (k == count / 2) drain();
    end
  endtask

  initial begin
    error_count = 0;
    sent_count  = 0;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    foreach (shadow_rows[i]) shadow_rows[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_cells();
    rest(3);
    test_bounds_edges();
    drain();
    test_empty_squares();
    rest(5);
    test_clear_grid();
    drain();
    test_random_traffic(1600 - sent_count);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("occupancy_grid_square_engine_unit: match");
    end else begin
      $display("occupancy_grid_square_engine_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("occupancy_grid_square_engine_unit: mismatch");
    $finish;
  end

endmodule
